>>> sv/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and constants of the clamped PID controller
// Widths, register indexes, datapath operation codes and the control program.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int unsigned DATA_W         = 16;  // config, input and output fields
  localparam int unsigned ERR_W          = 17;  // error e
  localparam int unsigned DERR_W         = 18;  // error difference
  localparam int unsigned ESUM_W         = 32;  // saturating integral
  localparam int unsigned KT_W           = 32;  // Ki * Ts
  localparam int unsigned MUL_A_W        = 33;
  localparam int unsigned MUL_B_W        = 18;
  localparam int unsigned PROD_W         = MUL_A_W + MUL_B_W;
  localparam int unsigned INT_W          = 64;  // Ki * Ts * integral, Q.24
  localparam int unsigned ISHIFT         = 17;  // Ts/2 and Q.24 to Q.8
  localparam int unsigned DSHIFT         = 16;  // derivative numerator scale
  localparam int unsigned ACC_W          = 53;  // sum of the three terms
  localparam int unsigned DIV_W          = 52;  // dividend bits
  localparam int unsigned DIV_RADIX_BITS = 4;   // quotient bits per cycle
  localparam int unsigned DIV_STEPS      = DIV_W / DIV_RADIX_BITS;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned STEP_W         = 4;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TS = 3'd3;

  localparam logic [DATA_W-1:0]        TS_RESET    = 16'd655;
  localparam logic signed [DATA_W-1:0] DRIVE_LIMIT = 16'sd25344;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ERROR,
    OP_UPDATE,
    OP_MUL_KT,
    OP_LOAD_KT,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_MUL_KD,
    OP_ITERM,
    OP_DIV,
    OP_DTERM,
    OP_OUT
  } op_e;

  // Sequencing of the step counter.
  typedef enum logic [2:0] {
    SEQ_NEXT,      // advance
    SEQ_GOTO,      // jump to target
    SEQ_WAIT_IN,   // hold until a transaction is taken in, then advance
    SEQ_LOOP,      // jump to target while the loop count is not zero
    SEQ_WAIT_OUT   // hold until the output slot is free, then jump to target
  } seq_e;

  typedef struct packed {
    op_e               op;
    seq_e              seq;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DIV  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_OUT  = 4'd11;

  // Control program.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      4'd0:    w = '{op: OP_IDLE,    seq: SEQ_WAIT_IN,  target: STEP_IDLE};
      4'd1:    w = '{op: OP_ERROR,   seq: SEQ_NEXT,     target: STEP_IDLE};
      4'd2:    w = '{op: OP_UPDATE,  seq: SEQ_NEXT,     target: STEP_IDLE};
      4'd3:    w = '{op: OP_MUL_KT,  seq: SEQ_NEXT,     target: STEP_IDLE};
      4'd4:    w = '{op: OP_LOAD_KT, seq: SEQ_NEXT,     target: STEP_IDLE};
      4'd5:    w = '{op: OP_MUL_HI,  seq: SEQ_NEXT,     target: STEP_IDLE};
      4'd6:    w = '{op: OP_MUL_LO,  seq: SEQ_NEXT,     target: STEP_IDLE};
      4'd7:    w = '{op: OP_MUL_KD,  seq: SEQ_NEXT,     target: STEP_IDLE};
      4'd8:    w = '{op: OP_ITERM,   seq: SEQ_NEXT,     target: STEP_IDLE};
      4'd9:    w = '{op: OP_DIV,     seq: SEQ_LOOP,     target: STEP_DIV};
      4'd10:   w = '{op: OP_DTERM,   seq: SEQ_NEXT,     target: STEP_IDLE};
      4'd11:   w = '{op: OP_OUT,     seq: SEQ_WAIT_OUT, target: STEP_IDLE};
      default: w = '{op: OP_IDLE,    seq: SEQ_GOTO,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> sv/pidc_if.sv
// ----------------------------------------------------------------------------
// pidc_if: valid/ready channels of the clamped PID controller
// One interface for the sample channel and one for the drive channel.
// ----------------------------------------------------------------------------
interface pidc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pidc_pkg::DATA_W-1:0]   command_value;
  logic signed [pidc_pkg::DATA_W-1:0]   measured_value;

  modport source (output valid, output command_value, output measured_value, input ready);
  modport sink   (input valid, input command_value, input measured_value, output ready);
endinterface

interface pidc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pidc_pkg::DATA_W-1:0]   drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

>>> sv/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped: positional PID controller with output clamp
// Microcoded sequencer over one shared multiplier and a radix-16 divider.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one sample per transaction (command_value, measured_value).
//   drv_o returns one drive_value per sample, signed Q8.8, clamped to +/-99.0.
//   The config port writes Kp, Ki, Kd (Q8.8) and Ts (Q0.16) by index 0..3;
//   write it only while no sample is in flight. Writes to other indexes drop.
// Timing:
//   A sample is taken while the step counter sits at its idle step. The
//   result is loaded into the output register at the last step, and the
//   next sample can be taken once the counter is back at its idle step, so
//   samples are processed one at a time. The length of a run is set by five
//   passes through the single 33x18 multiplier and by the divider for the
//   derivative term, which retires 4 quotient bits a cycle over 52 bits.
// Stalls:
//   The result sits in an output register. The next sample is accepted while
//   it waits; the program holds at its last step until the register frees up.
// Reset:
//   Clears integral, previous error and the output valid; gains return to
//   zero and Ts to 655 (about 10 ms).
// ----------------------------------------------------------------------------
module pid_controller_clamped (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  pidc_in_if.sink                               cmd_i,
  pidc_out_if.source                            drv_o,
  input  logic                                  cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [pidc_pkg::DATA_W-1:0]           cfg_data_i
);

  localparam int unsigned DW = pidc_pkg::DATA_W;

  // Configuration registers.
  logic [DW-1:0] kp_q, ki_q, kd_q, ts_q;
  logic [DW-1:0] ts_eff;

  // Sequencer.
  logic [pidc_pkg::STEP_W-1:0] step_q, step_d;
  logic [pidc_pkg::CNT_W-1:0]  cnt_q;
  pidc_pkg::ctrl_t             ctrl;

  // Controller state.
  logic signed [pidc_pkg::ESUM_W-1:0] esum_q;
  logic signed [pidc_pkg::ERR_W-1:0]  last_q;

  // Datapath registers.
  logic signed [DW-1:0]                cmd_q, meas_q;
  logic signed [pidc_pkg::ERR_W-1:0]   e_q;
  logic signed [pidc_pkg::DERR_W-1:0]  de_q;
  logic signed [pidc_pkg::PROD_W-1:0]  prod_q;
  logic [pidc_pkg::KT_W-1:0]           kt_q;
  logic signed [pidc_pkg::INT_W-1:0]   int_q;
  logic signed [pidc_pkg::ACC_W-1:0]   sum_q;
  logic [pidc_pkg::DIV_W-1:0]          quo_q;
  logic [DW-1:0]                       rem_q;
  logic                                dneg_q;
  logic signed [DW-1:0]                drive_q;
  logic                                out_valid_q;

  // Combinational datapath.
  logic signed [pidc_pkg::MUL_A_W-1:0]         mul_a;
  logic signed [pidc_pkg::MUL_B_W-1:0]         mul_b;
  logic signed [pidc_pkg::PROD_W-1:0]          prod_d;
  logic signed [pidc_pkg::ESUM_W:0]            esum_wide;
  logic signed [pidc_pkg::ESUM_W-1:0]          esum_d;
  logic signed [pidc_pkg::INT_W-1:0]           int_biased;
  logic signed [pidc_pkg::INT_W-pidc_pkg::ISHIFT-1:0] iterm;
  logic signed [pidc_pkg::PROD_W-1:0]          dmag;
  logic signed [pidc_pkg::ACC_W-1:0]           quo_s;
  logic [DW:0]                                 trial;
  logic [DW-1:0]                               rem_d;
  logic [pidc_pkg::DIV_W-1:0]                  quo_d;
  logic signed [DW-1:0]                        clamp_d;
  logic                                        in_fire, out_free;

  assign ctrl     = pidc_pkg::ucode(step_q);
  assign ts_eff   = (ts_q == '0) ? DW'(1) : ts_q;
  assign in_fire  = cmd_i.valid && cmd_i.ready;
  assign out_free = !out_valid_q || drv_o.ready;

  assign cmd_i.ready       = (ctrl.op == pidc_pkg::OP_IDLE);
  assign drv_o.valid       = out_valid_q;
  assign drv_o.drive_value = drive_q;

  // Config writes; unknown indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0;
      ki_q <= '0;
      kd_q <= '0;
      ts_q <= pidc_pkg::TS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pidc_pkg::REG_KP: kp_q <= cfg_data_i;
        pidc_pkg::REG_KI: ki_q <= cfg_data_i;
        pidc_pkg::REG_KD: kd_q <= cfg_data_i;
        pidc_pkg::REG_TS: ts_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Step counter: next step from the control word.
  always_comb begin
    step_d = step_q;
    case (ctrl.seq)
      pidc_pkg::SEQ_NEXT:     step_d = step_q + 1'b1;
      pidc_pkg::SEQ_GOTO:     step_d = ctrl.target;
      pidc_pkg::SEQ_WAIT_IN:  step_d = in_fire ? step_q + 1'b1 : step_q;
      pidc_pkg::SEQ_LOOP:     step_d = (cnt_q != '0) ? ctrl.target : step_q + 1'b1;
      pidc_pkg::SEQ_WAIT_OUT: step_d = out_free ? ctrl.target : step_q;
      default:                step_d = pidc_pkg::STEP_IDLE;
    endcase
  end

  // Shared multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      pidc_pkg::OP_UPDATE: begin
        mul_a = $signed({{(pidc_pkg::MUL_A_W-DW){1'b0}}, kp_q});
        mul_b = pidc_pkg::MUL_B_W'(e_q);
      end
      pidc_pkg::OP_MUL_KT: begin
        mul_a = $signed({{(pidc_pkg::MUL_A_W-DW){1'b0}}, ki_q});
        mul_b = $signed({{(pidc_pkg::MUL_B_W-DW){1'b0}}, ts_eff});
      end
      pidc_pkg::OP_MUL_HI: begin
        mul_a = $signed({1'b0, kt_q});
        mul_b = pidc_pkg::MUL_B_W'($signed(esum_q[pidc_pkg::ESUM_W-1 -: DW]));
      end
      pidc_pkg::OP_MUL_LO: begin
        mul_a = $signed({1'b0, kt_q});
        mul_b = $signed({{(pidc_pkg::MUL_B_W-DW){1'b0}}, esum_q[DW-1:0]});
      end
      pidc_pkg::OP_MUL_KD: begin
        mul_a = $signed({{(pidc_pkg::MUL_A_W-DW){1'b0}}, kd_q});
        mul_b = de_q;
      end
      default: ;
    endcase
  end

  assign prod_d = pidc_pkg::PROD_W'(mul_a) * pidc_pkg::PROD_W'(mul_b);

  // Saturating integral update.
  always_comb begin
    esum_wide = (pidc_pkg::ESUM_W + 1)'(esum_q) + (pidc_pkg::ESUM_W + 1)'(e_q);
    case (esum_wide[pidc_pkg::ESUM_W -: 2])
      2'b01:   esum_d = {1'b0, {(pidc_pkg::ESUM_W-1){1'b1}}};
      2'b10:   esum_d = {1'b1, {(pidc_pkg::ESUM_W-1){1'b0}}};
      default: esum_d = esum_wide[pidc_pkg::ESUM_W-1:0];
    endcase
  end

  // Integral term: divide by 2^17, truncating toward zero.
  assign int_biased = int_q + (int_q[pidc_pkg::INT_W-1]
                      ? pidc_pkg::INT_W'((64'd1 << pidc_pkg::ISHIFT) - 64'd1)
                      : '0);
  assign iterm      = int_biased[pidc_pkg::INT_W-1:pidc_pkg::ISHIFT];

  // Derivative numerator magnitude; sign kept aside for the divider.
  assign dmag  = prod_q[pidc_pkg::PROD_W-1] ? -prod_q : prod_q;
  assign quo_s = $signed({1'b0, quo_q});

  // Restoring divide by Ts, four quotient bits per cycle.
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int k = 0; k < int'(pidc_pkg::DIV_RADIX_BITS); k++) begin
      trial = {rem_d, quo_d[pidc_pkg::DIV_W-1]};
      quo_d = {quo_d[pidc_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, ts_eff}) begin
        rem_d    = DW'(trial - {1'b0, ts_eff});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[DW-1:0];
      end
    end
  end

  // Output clamp to +/-99.0.
  always_comb begin
    if (sum_q > pidc_pkg::ACC_W'(pidc_pkg::DRIVE_LIMIT)) begin
      clamp_d = pidc_pkg::DRIVE_LIMIT;
    end else if (sum_q < -pidc_pkg::ACC_W'(pidc_pkg::DRIVE_LIMIT)) begin
      clamp_d = -pidc_pkg::DRIVE_LIMIT;
    end else begin
      clamp_d = sum_q[DW-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= pidc_pkg::STEP_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      esum_q      <= '0;
      last_q      <= '0;
    end else begin
      step_q <= step_d;
      // Load a new result when the slot frees up, else drop a taken one.
      if ((ctrl.op == pidc_pkg::OP_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (drv_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (ctrl.op)
        pidc_pkg::OP_UPDATE: begin
          esum_q <= esum_d;
          last_q <= e_q;
        end
        pidc_pkg::OP_ITERM: cnt_q <= pidc_pkg::CNT_W'(pidc_pkg::DIV_STEPS - 1);
        pidc_pkg::OP_DIV:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (ctrl.op)
      pidc_pkg::OP_IDLE: begin
        if (in_fire) begin
          cmd_q  <= cmd_i.command_value;
          meas_q <= cmd_i.measured_value;
        end
      end
      pidc_pkg::OP_ERROR: e_q <= pidc_pkg::ERR_W'(cmd_q) - pidc_pkg::ERR_W'(meas_q);
      pidc_pkg::OP_UPDATE: begin
        de_q <= pidc_pkg::DERR_W'(e_q) - pidc_pkg::DERR_W'(last_q);
      end
      pidc_pkg::OP_MUL_KT:  sum_q <= pidc_pkg::ACC_W'(prod_q);
      pidc_pkg::OP_LOAD_KT: kt_q  <= prod_q[pidc_pkg::KT_W-1:0];
      pidc_pkg::OP_MUL_LO:  int_q <= pidc_pkg::INT_W'(prod_q) <<< pidc_pkg::DSHIFT;
      pidc_pkg::OP_MUL_KD:  int_q <= int_q + pidc_pkg::INT_W'(prod_q);
      pidc_pkg::OP_ITERM: begin
        sum_q  <= sum_q + pidc_pkg::ACC_W'(iterm);
        dneg_q <= prod_q[pidc_pkg::PROD_W-1];
        quo_q  <= {dmag[pidc_pkg::DIV_W-pidc_pkg::DSHIFT-1:0],
                   {pidc_pkg::DSHIFT{1'b0}}};
        rem_q  <= '0;
      end
      pidc_pkg::OP_DIV: begin
        quo_q <= quo_d;
        rem_q <= rem_d;
      end
      pidc_pkg::OP_DTERM: sum_q <= sum_q + (dneg_q ? -quo_s : quo_s);
      pidc_pkg::OP_OUT: begin
        if (out_free) begin
          drive_q <= clamp_d;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sv/pidc_checker.sv
// ----------------------------------------------------------------------------
// pidc_checker: port-level checks of the clamped PID controller
// Watches the sample and drive channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pidc_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [pidc_pkg::DATA_W-1:0] drive_value_i
);

  // Result never leaves the clamp window.
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (drive_value_i <= pidc_pkg::DRIVE_LIMIT) &&
                    (drive_value_i >= -pidc_pkg::DRIVE_LIMIT))
    else $error("drive_value outside clamp window");

  // One sample at a time: ready drops after a taken transaction.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second sample taken while one is in flight");

  // Pending result holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("drive result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(drive_value_i))
    else $error("drive_value changed while stalled");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (cmd_i.valid),
  .in_ready_i    (cmd_i.ready),
  .out_valid_i   (drv_o.valid),
  .out_ready_i   (drv_o.ready),
  .drive_value_i (drv_o.drive_value)
);
